FILE: hdl/lpd_pkg.sv
// Shared types and constants of the length-prefix deframer.
package lpd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    // Register indexes (byte address is 4 * index).
    localparam logic [1:0] REG_ORDER_MODE   = 2'd0;
    localparam logic [1:0] REG_MAX_BODY     = 2'd1;
    localparam logic [1:0] REG_DETECT_LIMIT = 2'd2;

    localparam logic [15:0] MAX_BODY_RST     = 16'd10000;
    localparam logic [15:0] DETECT_LIMIT_RST = 16'd65535;

    // Byte order modes and detected orders.
    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_LITTLE = 2'd1;
    localparam logic [1:0] MODE_BIG    = 2'd2;
    localparam logic [1:0] MODE_BAD    = 2'd3;

    localparam logic [1:0] ORD_NONE   = 2'd0;
    localparam logic [1:0] ORD_LITTLE = 2'd1;
    localparam logic [1:0] ORD_BIG    = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_TOOBIG = 2'd2;
    localparam logic [1:0] KIND_ORDER  = 2'd3;

    typedef struct packed {
        logic [1:0]  order_mode;
        logic [15:0] max_body;
        logic [15:0] detect_limit;
    } cfg_t;

    // Decision taken when the last header byte arrives.
    typedef struct packed {
        logic        has_result;
        logic [1:0]  kind;
        logic        halt;
        logic        to_body;
        logic [1:0]  found_order;
        logic [15:0] body_len;
    } hdr_dec_t;

endpackage

FILE: hdl/lpd_in_if.sv
// Input byte channel of the deframer.
interface lpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: hdl/lpd_out_if.sv
// Result channel of the deframer.
interface lpd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic       first;
    logic       last;

    modport source (output valid, output kind, output body_byte, output first,
                    output last, input ready);
    modport sink   (input valid, input kind, input body_byte, input first,
                    input last, output ready);
endinterface

FILE: hdl/lpd_regs.sv
// APB configuration registers of the deframer.
module lpd_regs
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order_mode   <= MODE_AUTO;
            cfg_reg.max_body     <= MAX_BODY_RST;
            cfg_reg.detect_limit <= DETECT_LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ORDER_MODE:   cfg_reg.order_mode   <= pwdata[1:0];
                REG_MAX_BODY:     cfg_reg.max_body     <= pwdata[15:0];
                REG_DETECT_LIMIT: cfg_reg.detect_limit <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ORDER_MODE:   prdata = {{(DATA_W-2){1'b0}}, cfg_reg.order_mode};
            REG_MAX_BODY:     prdata = {{(DATA_W-16){1'b0}}, cfg_reg.max_body};
            REG_DETECT_LIMIT: prdata = {{(DATA_W-16){1'b0}}, cfg_reg.detect_limit};
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: hdl/lpd_hdr_eval.sv
// Header decode: byte order choice, length checks and next-phase decision.
module lpd_hdr_eval
    import lpd_pkg::*;
(
    input  logic [23:0] header_bytes,
    input  logic [7:0]  last_byte,
    input  logic [1:0]  found_order,
    input  cfg_t        cfg,
    output hdr_dec_t    dec
);

    logic [31:0] le_len;
    logic [31:0] be_len;
    logic [31:0] len;
    logic        le_ok;
    logic        be_ok;
    logic        too_big;
    logic [1:0]  ord;
    logic [1:0]  found_next;

    assign le_len = {last_byte, header_bytes[23:16], header_bytes[15:8], header_bytes[7:0]};
    assign be_len = {header_bytes[7:0], header_bytes[15:8], header_bytes[23:16], last_byte};

    // A 32-bit length is below the 16-bit limit only if its upper half is zero.
    assign le_ok = (le_len[31:16] == 16'd0) && (le_len[15:0] < cfg.detect_limit);
    assign be_ok = (be_len[31:16] == 16'd0) && (be_len[15:0] < cfg.detect_limit);

    always_comb
    begin
        found_next = found_order;
        case (cfg.order_mode)
            MODE_LITTLE: ord = ORD_LITTLE;
            MODE_BIG:    ord = ORD_BIG;
            MODE_BAD:    ord = ORD_NONE;
            default:
            begin
                if (found_order == ORD_LITTLE || found_order == ORD_BIG)
                    ord = found_order;
                else if (le_ok)
                begin
                    ord        = ORD_LITTLE;
                    found_next = ORD_LITTLE;
                end
                else if (be_ok)
                begin
                    ord        = ORD_BIG;
                    found_next = ORD_BIG;
                end
                else
                    ord = ORD_NONE;
            end
        endcase
    end

    assign len     = (ord == ORD_LITTLE) ? le_len : be_len;
    assign too_big = (len[31:16] != 16'd0) || (len[15:0] > cfg.max_body);

    always_comb
    begin
        dec.has_result  = 1'b1;
        dec.kind        = KIND_EMPTY;
        dec.halt        = 1'b0;
        dec.to_body     = 1'b0;
        dec.found_order = found_next;
        dec.body_len    = len[15:0];
        if (ord == ORD_NONE)
        begin
            dec.kind = KIND_ORDER;
            dec.halt = 1'b1;
        end
        else if (too_big)
        begin
            dec.kind = KIND_TOOBIG;
            dec.halt = 1'b1;
        end
        else if (len[15:0] != 16'd0)
        begin
            dec.has_result = 1'b0;
            dec.to_body    = 1'b1;
        end
    end

endmodule

FILE: hdl/lpd_core.sv
// Deframer datapath: input register, framing state and result register.
module lpd_core
    import lpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    lpd_in_if.sink    in_ch,
    lpd_out_if.source out_ch
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_HALT   = 2'd2;
    localparam logic [1:0] LAST_HDR  = 2'(HEADER_BYTES - 1);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic [1:0]  phase_reg,        phase_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [23:0] header_bytes_reg, header_bytes_next;
    logic [15:0] body_left_reg,    body_left_next;
    logic        body_started_reg, body_started_next;
    logic [1:0]  found_order_reg,  found_order_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg,  out_kind_next;
    logic [7:0]  out_byte_reg,  out_byte_next;
    logic        out_first_reg, out_first_next;
    logic        out_last_reg,  out_last_next;

    logic        advance;
    logic        take_in;
    logic        has_res;
    hdr_dec_t    dec;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign take_in     = in_ch.valid && in_ch.ready;

    lpd_hdr_eval u_hdr_eval (
        .header_bytes (header_bytes_reg),
        .last_byte    (in_byte_reg),
        .found_order  (found_order_reg),
        .cfg          (cfg),
        .dec          (dec)
    );

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        header_bytes_next = header_bytes_reg;
        body_left_next    = body_left_reg;
        body_started_next = body_started_reg;
        found_order_next  = found_order_reg;
        has_res           = 1'b0;
        out_kind_next     = KIND_BYTE;
        out_byte_next     = 8'd0;
        out_first_next    = 1'b0;
        out_last_next     = 1'b0;

        if (advance)
        begin
            case (phase_reg)
                PH_BODY:
                begin
                    has_res           = 1'b1;
                    out_byte_next     = in_byte_reg;
                    out_first_next    = !body_started_reg;
                    out_last_next     = (body_left_reg <= 16'd1);
                    body_started_next = 1'b1;
                    if (body_left_reg <= 16'd1)
                    begin
                        body_left_next    = 16'd0;
                        body_started_next = 1'b0;
                        phase_next        = PH_HEADER;
                        header_count_next = 2'd0;
                        header_bytes_next = 24'd0;
                    end
                    else
                        body_left_next = body_left_reg - 16'd1;
                end
                PH_HEADER:
                begin
                    if (header_count_reg != LAST_HDR)
                    begin
                        case (header_count_reg)
                            2'd0:    header_bytes_next[7:0]   = in_byte_reg;
                            2'd1:    header_bytes_next[15:8]  = in_byte_reg;
                            default: header_bytes_next[23:16] = in_byte_reg;
                        endcase
                        header_count_next = header_count_reg + 2'd1;
                    end
                    else
                    begin
                        header_count_next = 2'd0;
                        header_bytes_next = 24'd0;
                        found_order_next  = dec.found_order;
                        has_res           = dec.has_result;
                        out_kind_next     = dec.kind;
                        if (dec.halt)
                            phase_next = PH_HALT;
                        else if (dec.to_body)
                        begin
                            phase_next        = PH_BODY;
                            body_left_next    = dec.body_len;
                            body_started_next = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        out_valid_next = (out_valid_reg && !out_ch.ready) || has_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_HEADER;
            header_count_reg <= 2'd0;
            header_bytes_reg <= 24'd0;
            body_left_reg    <= 16'd0;
            body_started_reg <= 1'b0;
            found_order_reg  <= ORD_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            header_bytes_reg <= header_bytes_next;
            body_left_reg    <= body_left_next;
            body_started_reg <= body_started_next;
            found_order_reg  <= found_order_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_byte_reg <= in_ch.data_byte;
        if (has_res)
        begin
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            out_first_reg <= out_first_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.kind      = out_kind_reg;
    assign out_ch.body_byte = out_byte_reg;
    assign out_ch.first     = out_first_reg;
    assign out_ch.last      = out_last_reg;

endmodule

FILE: hdl/length_prefix_deframer_unit.sv
// Top level of the length-prefix deframer: configuration port and datapath.
//
// The block splits a byte stream into messages, each a four-byte length
// header followed by that many body bytes. Bytes arrive on in_ch, one per
// request; results leave on out_ch, one request per body byte (with first
// and last marks), one for an empty message, or one error report.
// Byte order is fixed by order_mode or, in auto mode, detected once from the
// first header. A byte order error or a length above max_body is reported
// once, after which the block drops every input byte until reset.
// A result request is registered first in the input register and then in the
// result register before it appears on out_ch; only the last header byte
// produces one, for an empty message or an error report.
// Throughput is one byte per clock while out_ch is not stalled, set by the
// single pass of decode logic between the input and result registers.
// When the receiver stalls, the result register holds its request and the
// input register takes at most one more byte, after which in_ch ready drops.
// Reset empties both registers, clears the framing state and the detected byte
// order, and loads the configuration registers with their reset values.
// The APB port takes writes in the usual setup and access cycles; pready is
// always high. Configuration should be changed only while the block is idle.
module length_prefix_deframer_unit
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    lpd_in_if.sink            in_ch,
    lpd_out_if.source         out_ch
);

    // Current register values, shared by the header decoder.
    cfg_t cfg;

    lpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register, framing state and result register.
    lpd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
